[rtl/rcyl_pkg.sv]
// Shared types and constants for the ray / finite cylinder intersection core.
// No dependencies.
package rcyl_pkg;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS   = 2'd0,
    CFG_BOTTOM_Y = 2'd1,
    CFG_LENGTH   = 2'd2
  } cfg_idx_t;

  // per-transaction control that rides along the cell chains
  typedef struct packed {
    logic vld;   // slot holds a transaction
    logic live;  // result may still be a hit
  } rcyl_ctl_t;

endpackage

[rtl/rcyl_if.sv]
// Valid/ready channel interfaces for rays in and hit results out.
// Depends on nothing; width follows COORD_WIDTH.
interface rcyl_in_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] origin_x;
  logic signed [COORD_WIDTH-1:0] origin_y;
  logic signed [COORD_WIDTH-1:0] origin_z;
  logic signed [COORD_WIDTH-1:0] dir_x;
  logic signed [COORD_WIDTH-1:0] dir_y;
  logic signed [COORD_WIDTH-1:0] dir_z;

  modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  output ready);
endinterface

interface rcyl_out_if #(parameter int COORD_WIDTH = 32);
  logic                   valid;
  logic                   ready;
  logic                   near_hit;
  logic [COORD_WIDTH-2:0] near_t;
  logic                   far_hit;
  logic [COORD_WIDTH-2:0] far_t;

  modport source (output valid, near_hit, near_t, far_hit, far_t, input ready);
  modport sink   (input valid, near_hit, near_t, far_hit, far_t, output ready);
endinterface

[rtl/rcyl_sqrt_cell.sv]
// One cell of the pipelined integer square root: resolves one root bit.
// Depends on rcyl_pkg.
module rcyl_sqrt_cell #(
  parameter int RB = 64,  // root bits
  parameter int SW = 1    // sideband width
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  rcyl_pkg::rcyl_ctl_t ctl_i,
  input  logic [2*RB-1:0]     rad_i,
  input  logic [RB+1:0]       rem_i,
  input  logic [RB-1:0]       root_i,
  input  logic [SW-1:0]       side_i,
  output rcyl_pkg::rcyl_ctl_t ctl_o,
  output logic [2*RB-1:0]     rad_o,
  output logic [RB+1:0]       rem_o,
  output logic [RB-1:0]       root_o,
  output logic [SW-1:0]       side_o
);
  import rcyl_pkg::*;

  rcyl_ctl_t       ctl_r;
  logic [2*RB-1:0] rad_r;
  logic [RB+1:0]   rem_r, rem_nxt, rem_sh, trial, diff;
  logic [RB-1:0]   root_r, root_nxt;
  logic [SW-1:0]   side_r;
  logic            ge;

  always_comb begin
    rem_sh   = {rem_i[RB-1:0], rad_i[2*RB-1 -: 2]};
    trial    = {root_i, 2'b01};
    diff     = rem_sh - trial;
    ge       = (rem_sh >= trial);
    rem_nxt  = ge ? diff : rem_sh;
    root_nxt = {root_i[RB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_i << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= side_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign side_o = side_r;

endmodule

[rtl/rcyl_div_cell.sv]
// One cell of the pipelined restoring divider: resolves one quotient bit.
// Depends on rcyl_pkg.
module rcyl_div_cell #(
  parameter int DW = 64,  // divisor width
  parameter int NB = 50,  // numerator bits still to bring down / quotient bits
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  rcyl_pkg::rcyl_ctl_t ctl_i,
  input  logic [DW-1:0]       a_i,
  input  logic [DW-1:0]       rem_i,
  input  logic [NB-1:0]       num_i,
  input  logic [NB-1:0]       q_i,
  input  logic [SW-1:0]       side_i,
  output rcyl_pkg::rcyl_ctl_t ctl_o,
  output logic [DW-1:0]       a_o,
  output logic [DW-1:0]       rem_o,
  output logic [NB-1:0]       num_o,
  output logic [NB-1:0]       q_o,
  output logic [SW-1:0]       side_o
);
  import rcyl_pkg::*;

  rcyl_ctl_t     ctl_r;
  logic [DW-1:0] a_r, rem_r, rem_nxt;
  logic [DW:0]   rs, diff;
  logic [NB-1:0] num_r, q_r, q_nxt;
  logic [SW-1:0] side_r;
  logic          ge;

  always_comb begin
    rs      = {rem_i, num_i[NB-1]};
    diff    = rs - {1'b0, a_i};
    ge      = (rs >= {1'b0, a_i});
    rem_nxt = ge ? diff[DW-1:0] : rs[DW-1:0];
    q_nxt   = {q_i[NB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r    <= a_i;
      rem_r  <= rem_nxt;
      num_r  <= num_i << 1;
      q_r    <= q_nxt;
      side_r <= side_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign a_o    = a_r;
  assign rem_o  = rem_r;
  assign num_o  = num_r;
  assign q_o    = q_r;
  assign side_o = side_r;

endmodule

[rtl/ray_cylinder_intersect_core.sv]
// Built from one square root cell per root bit and one divider cell per quotient bit.
// Throughput: one ray per cycle; the whole pipeline holds while a result waits unread.
// Reset (rst_n low, synchronous) empties the pipeline and loads radius 1.0,
// bottom_y 0, length 1.0.
module ray_cylinder_intersect_core #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  rcyl_in_if.sink                        in_ch,
  rcyl_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [rcyl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0]         cfg_data
);
  import rcyl_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int RB  = 2*W;        // root bits
  localparam int DW  = 2*W;        // divisor width
  localparam int QB  = W + 2 + F;  // quotient bits kept
  localparam int KL  = QB/2;
  localparam int KH  = QB - KL;
  localparam int PW  = W + QB + 1; // dy*t product
  localparam int YW  = PW + 1;
  localparam int SSW = 2*W + (2*W+1) + DW + 1;
  localparam int DSW = 2*W + 1;
  localparam logic [W-2:0] ONE_FX = {{(W-2){1'b0}}, 1'b1} << F;
  localparam logic [QB-1:0] MAXT  = {{(QB-W+1){1'b0}}, {(W-1){1'b1}}};

  // ---------------- configuration ----------------
  logic [W-2:0]        radius_r, length_r;
  logic signed [W-1:0] bottom_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= ONE_FX;
      bottom_y_r <= '0;
      length_r   <= ONE_FX;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RADIUS:   radius_r   <= cfg_data[W-2:0];
        CFG_BOTTOM_Y: bottom_y_r <= cfg_data;
        CFG_LENGTH:   length_r   <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic en, out_v_r;
  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;

  // valid pipe of the front and back stages
  logic v1_r, v2_r, v3_r, v4_r, e1_v_r, e2_v_r, e3_v_r;

  // ---------------- S1: coordinate products ----------------
  logic signed [2*W-1:0] pxx_r, pzz_r, phx_r, phz_r, pox_r, poz_r;
  logic [2*W-3:0]        prr_r;
  logic signed [W-1:0]   oy1_r, dy1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pxx_r <= in_ch.dir_x * in_ch.dir_x;
      pzz_r <= in_ch.dir_z * in_ch.dir_z;
      phx_r <= in_ch.origin_x * in_ch.dir_x;
      phz_r <= in_ch.origin_z * in_ch.dir_z;
      pox_r <= in_ch.origin_x * in_ch.origin_x;
      poz_r <= in_ch.origin_z * in_ch.origin_z;
      prr_r <= radius_r * radius_r;
      oy1_r <= in_ch.origin_y;
      dy1_r <= in_ch.dir_y;
    end
  end

  // ---------------- S2: a, h, c ----------------
  logic [2*W-1:0]      a2_r;
  logic signed [2*W:0] h2_r, c2_r;
  logic signed [W-1:0] oy2_r, dy2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r  <= $unsigned(pxx_r) + $unsigned(pzz_r);
      h2_r  <= $signed({phx_r[2*W-1], phx_r}) + $signed({phz_r[2*W-1], phz_r});
      c2_r  <= $signed({pox_r[2*W-1], pox_r}) + $signed({poz_r[2*W-1], poz_r})
               - $signed({3'b000, prr_r});
      oy2_r <= oy1_r;
      dy2_r <= dy1_r;
    end
  end

  // ---------------- S3: partial products of h*h and a*|c| ----------------
  logic [2*W:0]   h_neg, c_neg;
  logic [2*W-1:0] habs, cabs;
  logic [2*W-1:0] p_hhh_r, p_hhl_r, p_hll_r, p_ahch_r, p_ahcl_r, p_alch_r, p_alcl_r;
  logic [2*W-1:0] a3_r;
  logic signed [2*W:0] h3_r;
  logic           csign3_r;
  logic signed [W-1:0] oy3_r, dy3_r;

  always_comb begin
    h_neg = -h2_r;
    c_neg = -c2_r;
    habs  = h2_r[2*W] ? h_neg[2*W-1:0] : h2_r[2*W-1:0];
    cabs  = c2_r[2*W] ? c_neg[2*W-1:0] : c2_r[2*W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_hhh_r  <= habs[2*W-1:W] * habs[2*W-1:W];
      p_hhl_r  <= habs[2*W-1:W] * habs[W-1:0];
      p_hll_r  <= habs[W-1:0]   * habs[W-1:0];
      p_ahch_r <= a2_r[2*W-1:W] * cabs[2*W-1:W];
      p_ahcl_r <= a2_r[2*W-1:W] * cabs[W-1:0];
      p_alch_r <= a2_r[W-1:0]   * cabs[2*W-1:W];
      p_alcl_r <= a2_r[W-1:0]   * cabs[W-1:0];
      a3_r     <= a2_r;
      h3_r     <= h2_r;
      csign3_r <= c2_r[2*W];
      oy3_r    <= oy2_r;
      dy3_r    <= dy2_r;
    end
  end

  // ---------------- S4: combine partial products ----------------
  logic [4*W-1:0] hh4_r, ac4_r;
  logic [2*W-1:0] a4_r;
  logic signed [2*W:0] h4_r;
  logic           csign4_r;
  logic signed [W-1:0] oy4_r, dy4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hh4_r    <= {p_hhh_r, p_hll_r} + ({{(2*W){1'b0}}, p_hhl_r} << (W+1));
      ac4_r    <= {p_ahch_r, p_alcl_r} + ({{(2*W){1'b0}}, p_ahcl_r} << W)
                  + ({{(2*W){1'b0}}, p_alch_r} << W);
      a4_r     <= a3_r;
      h4_r     <= h3_r;
      csign4_r <= csign3_r;
      oy4_r    <= oy3_r;
      dy4_r    <= dy3_r;
    end
  end

  // ---------------- S5: discriminant ----------------
  logic [4*W:0]     dsc;
  logic [4*W-1:0]   rad5_r;
  rcyl_ctl_t        ctl5_r;
  logic [SSW-1:0]   side5_r;

  assign dsc = csign4_r ? ({1'b0, hh4_r} + {1'b0, ac4_r}) : ({1'b0, hh4_r} - {1'b0, ac4_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r <= '0;
    end else if (en) begin
      ctl5_r.vld  <= v4_r;
      ctl5_r.live <= (a4_r != '0) && !dsc[4*W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad5_r  <= dsc[4*W-1:0];
      side5_r <= {oy4_r, dy4_r, h4_r, a4_r, (dsc != '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // ---------------- square root chain ----------------
  rcyl_ctl_t        sq_ctl  [0:RB];
  logic [2*RB-1:0]  sq_rad  [0:RB];
  logic [RB+1:0]    sq_rem  [0:RB];
  logic [RB-1:0]    sq_root [0:RB];
  logic [SSW-1:0]   sq_side [0:RB];

  assign sq_ctl[0]  = ctl5_r;
  assign sq_rad[0]  = rad5_r;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_side[0] = side5_r;

  for (genvar k = 0; k < RB; k++) begin : g_sqrt
    rcyl_sqrt_cell #(.RB(RB), .SW(SSW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (sq_ctl[k]),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .side_i (sq_side[k]),
      .ctl_o  (sq_ctl[k+1]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .side_o (sq_side[k+1])
    );
  end

  // ---------------- D0: root numerators, divider setup ----------------
  logic signed [W-1:0] sq_oy, sq_dy;
  logic signed [2*W:0] sq_h;
  logic [DW-1:0]       sq_a;
  logic                sq_nz;
  logic signed [2*W+1:0] mh, m1, m2;
  logic [DW-1:0]       r1_init, r2_init;
  logic                pos1, pos2;

  assign {sq_oy, sq_dy, sq_h, sq_a, sq_nz} = sq_side[RB];

  always_comb begin
    mh      = -$signed({sq_h[2*W], sq_h});
    m1      = mh - $signed({2'b00, sq_root[RB]});
    m2      = mh + $signed({2'b00, sq_root[RB]});
    pos1    = !m1[2*W+1] && (m1 != '0);
    pos2    = !m2[2*W+1] && (m2 != '0);
    r1_init = {{(DW-W+1){1'b0}}, m1[2*W:W+2]};
    r2_init = {{(DW-W+1){1'b0}}, m2[2*W:W+2]};
  end

  rcyl_ctl_t      d0_ctl1_r, d0_ctl2_r;
  logic [DW-1:0]  d0_a_r, d0_r1_r, d0_r2_r;
  logic [QB-1:0]  d0_n1_r, d0_n2_r;
  logic [DSW-1:0] d0_side1_r;
  logic           d0_ovf2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d0_ctl1_r <= '0;
      d0_ctl2_r <= '0;
    end else if (en) begin
      d0_ctl1_r.vld  <= sq_ctl[RB].vld;
      d0_ctl1_r.live <= sq_ctl[RB].live && pos1;
      d0_ctl2_r.vld  <= sq_ctl[RB].vld;
      d0_ctl2_r.live <= sq_ctl[RB].live && sq_nz && pos2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_a_r     <= sq_a;
      d0_r1_r    <= r1_init;
      d0_r2_r    <= r2_init;
      d0_n1_r    <= {m1[W+1:0], {F{1'b0}}};
      d0_n2_r    <= {m2[W+1:0], {F{1'b0}}};
      d0_side1_r <= {(r1_init >= sq_a), sq_oy, sq_dy};
      d0_ovf2_r  <= (r2_init >= sq_a);
    end
  end

  // ---------------- divider chains (near and far root) ----------------
  rcyl_ctl_t      dv1_ctl [0:QB];
  logic [DW-1:0]  dv1_a   [0:QB];
  logic [DW-1:0]  dv1_rem [0:QB];
  logic [QB-1:0]  dv1_num [0:QB];
  logic [QB-1:0]  dv1_q   [0:QB];
  logic [DSW-1:0] dv1_side[0:QB];
  rcyl_ctl_t      dv2_ctl [0:QB];
  logic [DW-1:0]  dv2_a   [0:QB];
  logic [DW-1:0]  dv2_rem [0:QB];
  logic [QB-1:0]  dv2_num [0:QB];
  logic [QB-1:0]  dv2_q   [0:QB];
  logic [0:0]     dv2_side[0:QB];

  assign dv1_ctl[0]  = d0_ctl1_r;
  assign dv1_a[0]    = d0_a_r;
  assign dv1_rem[0]  = d0_r1_r;
  assign dv1_num[0]  = d0_n1_r;
  assign dv1_q[0]    = '0;
  assign dv1_side[0] = d0_side1_r;
  assign dv2_ctl[0]  = d0_ctl2_r;
  assign dv2_a[0]    = d0_a_r;
  assign dv2_rem[0]  = d0_r2_r;
  assign dv2_num[0]  = d0_n2_r;
  assign dv2_q[0]    = '0;
  assign dv2_side[0] = d0_ovf2_r;

  for (genvar k = 0; k < QB; k++) begin : g_div
    rcyl_div_cell #(.DW(DW), .NB(QB), .SW(DSW)) u_near (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (dv1_ctl[k]),
      .a_i    (dv1_a[k]),
      .rem_i  (dv1_rem[k]),
      .num_i  (dv1_num[k]),
      .q_i    (dv1_q[k]),
      .side_i (dv1_side[k]),
      .ctl_o  (dv1_ctl[k+1]),
      .a_o    (dv1_a[k+1]),
      .rem_o  (dv1_rem[k+1]),
      .num_o  (dv1_num[k+1]),
      .q_o    (dv1_q[k+1]),
      .side_o (dv1_side[k+1])
    );
    rcyl_div_cell #(.DW(DW), .NB(QB), .SW(1)) u_far (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .ctl_i  (dv2_ctl[k]),
      .a_i    (dv2_a[k]),
      .rem_i  (dv2_rem[k]),
      .num_i  (dv2_num[k]),
      .q_i    (dv2_q[k]),
      .side_i (dv2_side[k]),
      .ctl_o  (dv2_ctl[k+1]),
      .a_o    (dv2_a[k+1]),
      .rem_o  (dv2_rem[k+1]),
      .num_o  (dv2_num[k+1]),
      .q_o    (dv2_q[k+1]),
      .side_o (dv2_side[k+1])
    );
  end

  // ---------------- E1: saturate quotient on overflow ----------------
  logic                dv_ovf1;
  logic signed [W-1:0] dv_oy, dv_dy;
  logic [QB-1:0]       qe1, qe2;

  assign {dv_ovf1, dv_oy, dv_dy} = dv1_side[QB];
  assign qe1 = dv_ovf1 ? '1 : dv1_q[QB];
  assign qe2 = dv2_side[QB][0] ? '1 : dv2_q[QB];

  logic [QB-1:0]       e1_q1_r, e1_q2_r;
  logic                e1_h1_r, e1_h2_r;
  logic signed [W-1:0] e1_oy_r, e1_dy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e1_q1_r <= qe1;
      e1_q2_r <= qe2;
      e1_h1_r <= dv1_ctl[QB].live && (qe1 != '0);
      e1_h2_r <= dv2_ctl[QB].vld && dv2_ctl[QB].live && (qe2 != '0);
      e1_oy_r <= dv_oy;
      e1_dy_r <= dv_dy;
    end
  end

  // ---------------- E2: dy * t partial products ----------------
  logic signed [W+KL:0] e2_pl1_r, e2_pl2_r;
  logic signed [W+KH:0] e2_ph1_r, e2_ph2_r;
  logic [QB-1:0]        e2_q1_r, e2_q2_r;
  logic                 e2_h1_r, e2_h2_r;
  logic signed [W-1:0]  e2_oy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      e2_pl1_r <= e1_dy_r * $signed({1'b0, e1_q1_r[KL-1:0]});
      e2_ph1_r <= e1_dy_r * $signed({1'b0, e1_q1_r[QB-1:KL]});
      e2_pl2_r <= e1_dy_r * $signed({1'b0, e1_q2_r[KL-1:0]});
      e2_ph2_r <= e1_dy_r * $signed({1'b0, e1_q2_r[QB-1:KL]});
      e2_q1_r  <= e1_q1_r;
      e2_q2_r  <= e1_q2_r;
      e2_h1_r  <= e1_h1_r;
      e2_h2_r  <= e1_h2_r;
      e2_oy_r  <= e1_oy_r;
    end
  end

  // ---------------- E3: hit height, saturated t ----------------
  logic signed [PW-1:0] prod1, prod2, p1, p2;
  logic signed [YW-1:0] e3_y1_r, e3_y2_r;
  logic [W-2:0]         e3_t1_r, e3_t2_r;
  logic                 e3_h1_r, e3_h2_r;

  always_comb begin
    prod1 = (PW'(e2_ph1_r) <<< KL) + PW'(e2_pl1_r);
    prod2 = (PW'(e2_ph2_r) <<< KL) + PW'(e2_pl2_r);
    p1    = prod1 >>> F;
    p2    = prod2 >>> F;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e3_y1_r <= YW'(e2_oy_r) + YW'(p1);
      e3_y2_r <= YW'(e2_oy_r) + YW'(p2);
      e3_t1_r <= (e2_q1_r > MAXT) ? MAXT[W-2:0] : e2_q1_r[W-2:0];
      e3_t2_r <= (e2_q2_r > MAXT) ? MAXT[W-2:0] : e2_q2_r[W-2:0];
      e3_h1_r <= e2_h1_r;
      e3_h2_r <= e2_h2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
      e2_v_r <= 1'b0;
      e3_v_r <= 1'b0;
    end else if (en) begin
      e1_v_r <= dv1_ctl[QB].vld;
      e2_v_r <= e1_v_r;
      e3_v_r <= e2_v_r;
    end
  end

  // ---------------- E4: span test into output register ----------------
  logic signed [YW-1:0] lo_ext, hi_ext;
  logic                 ok1, ok2;
  logic                 near_hit_r, far_hit_r;
  logic [W-2:0]         near_t_r, far_t_r;

  always_comb begin
    lo_ext = YW'(bottom_y_r);
    hi_ext = lo_ext + $signed({{(YW-W+1){1'b0}}, length_r});
    ok1    = e3_h1_r && (e3_y1_r > lo_ext) && (e3_y1_r < hi_ext);
    ok2    = e3_h2_r && (e3_y2_r > lo_ext) && (e3_y2_r < hi_ext);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= e3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near_hit_r <= ok1;
      near_t_r   <= ok1 ? e3_t1_r : '0;
      far_hit_r  <= ok2;
      far_t_r    <= ok2 ? e3_t2_r : '0;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.near_hit = near_hit_r;
  assign out_ch.near_t   = near_t_r;
  assign out_ch.far_hit  = far_hit_r;
  assign out_ch.far_t    = far_t_r;

endmodule

[rtl/rcyl_checker.sv]
// Port-level checks for ray_cylinder_intersect_core, attached by bind.
// Depends on the core's channel ports only.
module rcyl_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   near_hit,
  input logic [COORD_WIDTH-2:0] near_t,
  input logic                   far_hit,
  input logic [COORD_WIDTH-2:0] far_t
);

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a held result freezes the whole pipeline, so no ray can enter
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("ray accepted while result stalled");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(near_hit) && $stable(near_t)
                                && $stable(far_hit) && $stable(far_t))
    else $error("stalled result changed");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && near_hit && far_hit |-> far_t >= near_t)
    else $error("far hit nearer than near hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (near_hit || near_t == '0) && (far_hit || far_t == '0))
    else $error("t nonzero on a miss");

endmodule

bind ray_cylinder_intersect_core rcyl_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rcyl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .near_hit  (out_ch.near_hit),
  .near_t    (out_ch.near_t),
  .far_hit   (out_ch.far_hit),
  .far_t     (out_ch.far_t)
);

[bench/tb_rcyl_if_note.sv]
`timescale 1ns / 100ps
// Test-side shared types for the cylinder intersection bench.
// Depends on nothing; channel interfaces come from rtl/rcyl_if.sv.
package tb_rcyl_types;

  typedef struct {
    logic signed [31:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct {
    bit        near_hit;
    bit [30:0] near_t;
    bit        far_hit;
    bit [30:0] far_t;
  } hit_t;

endpackage

[bench/tb_ray_cylinder_intersect_core.sv]
`timescale 1ns / 100ps
// Bench for ray_cylinder_intersect_core: random and directed rays, exact predictor.
// Depends on rcyl_pkg, rcyl_if.sv and tb_rcyl_types.
module tb_ray_cylinder_intersect_core;
  import rcyl_pkg::*;
  import tb_rcyl_types::*;

  typedef logic signed [255:0] wide_t;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int ONE = 65536;
  localparam int LIMIT = 300000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RADIUS;
  logic [31:0] cfg_data = 0;

  rcyl_in_if  #(.COORD_WIDTH(32)) in_ch ();
  rcyl_out_if #(.COORD_WIDTH(32)) out_ch ();

  ray_cylinder_intersect_core #(.FRAC_BITS(16), .COORD_WIDTH(32)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // shadow registers
  logic [30:0] cyl_radius = 31'd65536;
  logic signed [31:0] cyl_bottom = 0;
  logic [30:0] cyl_length = 31'd65536;

  ray_t pending_rays[$];
  hit_t expected_hits[$];
  ray_t cur_ray;
  int send_idle = 0, recv_idle = 0;
  int errors = 0, rays_sent = 0, hits_checked = 0, settings_used = 0;
  int cycles = 0;

  function automatic wide_t floor_div(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if (n < 0 && q * d != n) q = q - 1;
    return q;
  endfunction

  function automatic wide_t int_sqrt(wide_t n);
    wide_t res, trial;
    res = 0;
    for (int b = 70; b >= 0; b--) begin
      trial = res | (wide_t'(1) << b);
      if (trial * trial <= n) res = trial;
    end
    return res;
  endfunction

  function automatic bit root_in_span(wide_t t, ray_t r);
    wide_t y, oy, dy, lo, hi;
    if (t <= 0) return 0;
    oy = r.oy;
    dy = r.dy;
    lo = cyl_bottom;
    hi = lo + {225'b0, cyl_length};
    y = oy + ((dy * t) >>> 16);
    return (y > lo) && (y < hi);
  endfunction

  function automatic bit [30:0] clip_t(wide_t t);
    wide_t tmax;
    tmax = 0;
    tmax[30:0] = '1;
    if (t > tmax) return '1;
    return t[30:0];
  endfunction

  function automatic hit_t hit_test(ray_t r);
    wide_t ox, oz, dx, dz, rr, a, h, c, disc, s, t1, t2;
    hit_t res;
    res = '{0, 0, 0, 0};
    ox = r.ox; oz = r.oz; dx = r.dx; dz = r.dz;
    rr = {225'b0, cyl_radius};
    a = dx * dx + dz * dz;
    h = ox * dx + oz * dz;
    c = ox * ox + oz * oz - rr * rr;
    disc = h * h - a * c;
    if (a == 0 || disc < 0) return res;
    if (disc == 0) begin
      t1 = floor_div(-h * 65536, a);
      if (root_in_span(t1, r)) begin
        res.near_hit = 1;
        res.near_t = clip_t(t1);
      end
    end else begin
      s = int_sqrt(disc);
      t1 = floor_div((-h - s) * 65536, a);
      t2 = floor_div((-h + s) * 65536, a);
      if (root_in_span(t1, r)) begin
        res.near_hit = 1;
        res.near_t = clip_t(t1);
      end
      if (root_in_span(t2, r)) begin
        res.far_hit = 1;
        res.far_t = clip_t(t2);
      end
    end
    return res;
  endfunction

  function automatic void add_ray(ray_t r);
    pending_rays = {pending_rays, r};
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d expected %0d", hits_checked, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_hits = {expected_hits, hit_test(cur_ray)};
        rays_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_rays.size() > 0 && $urandom_range(99) >= send_idle) begin
          cur_ray = pending_rays.pop_front();
          in_ch.origin_x <= cur_ray.ox;
          in_ch.origin_y <= cur_ray.oy;
          in_ch.origin_z <= cur_ray.oz;
          in_ch.dir_x <= cur_ray.dx;
          in_ch.dir_y <= cur_ray.dy;
          in_ch.dir_z <= cur_ray.dz;
          in_ch.valid <= 1;
        end else begin
          in_ch.valid <= 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    hit_t want;
    if (!rst_n) begin
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_hits.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = expected_hits.pop_front();
          if (out_ch.near_hit !== want.near_hit)
            report_mismatch("near_hit", out_ch.near_hit, want.near_hit);
          if (out_ch.near_t !== want.near_t)
            report_mismatch("near_t", out_ch.near_t, want.near_t);
          if (out_ch.far_hit !== want.far_hit)
            report_mismatch("far_hit", out_ch.far_hit, want.far_hit);
          if (out_ch.far_t !== want.far_t)
            report_mismatch("far_t", out_ch.far_t, want.far_t);
        end
        hits_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout with %0d results outstanding", expected_hits.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_RADIUS:   cyl_radius = val[30:0];
      CFG_BOTTOM_Y: cyl_bottom = val;
      CFG_LENGTH:   cyl_length = val[30:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_rays.size() != 0 || expected_hits.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint spread(longint s);
    return longint'($urandom_range(32'(2 * s))) - s;
  endfunction

  function automatic ray_t make_ray();
    ray_t r;
    longint span, mid, ox, oz, jit;
    if ($urandom_range(9) == 0) begin
      r = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return r;
    end
    span = 4 * longint'(cyl_radius);
    if (span < longint'(ONE)) span = longint'(ONE);
    if (span > 64'd1 << 30) span = 64'd1 << 30;
    jit = span / 8 + 1;
    mid = longint'(cyl_bottom) + longint'(cyl_length) / 2;
    ox = spread(span);
    oz = spread(span);
    r.ox = clamp32(ox);
    r.oz = clamp32(oz);
    r.oy = clamp32(mid + spread(longint'(cyl_length) / 2 + 1));
    if ($urandom_range(9) < 7) begin
      // aim roughly at the axis
      r.dx = clamp32(-(ox >>> $urandom_range(3)) + spread(jit));
      r.dz = clamp32(-(oz >>> $urandom_range(3)) + spread(jit));
    end else begin
      r.dx = clamp32(spread(longint'(2 * ONE)));
      r.dz = clamp32(spread(longint'(2 * ONE)));
    end
    r.dy = clamp32(spread(longint'(cyl_length) / 4 + 1));
    return r;
  endfunction

  task automatic run_random(int n);
    repeat (n) add_ray(make_ray());
    drain();
    settings_used++;
  endtask

  initial begin
    in_ch.valid = 0;
    in_ch.origin_x = 0; in_ch.origin_y = 0; in_ch.origin_z = 0;
    in_ch.dir_x = 0; in_ch.dir_y = 0; in_ch.dir_z = 0;
    out_ch.ready = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    send_idle = 7;
    recv_idle = 69;
    // reset settings: radius 1, span 0..1
    add_ray('{-2 * ONE, ONE / 2, 0, ONE, 0, 0});        // two hits
    add_ray('{-2 * ONE, ONE / 2, ONE, ONE, 0, 0});      // tangent
    add_ray('{0, ONE / 2, 0, 0, ONE, 0});               // axis parallel
    add_ray('{-2 * ONE, ONE / 2, 2 * ONE, ONE, 0, 0});  // misses
    add_ray('{2 * ONE, ONE / 2, 0, ONE, 0, 0});         // behind
    add_ray('{0, ONE / 2, 0, 0, 0, ONE});               // inside
    add_ray('{-2 * ONE, 3 * ONE, 0, ONE, 0, 0});        // above span
    add_ray('{-2 * ONE, ONE / 2, 0, ONE, ONE, 0});      // exits top
    add_ray('{-2 * ONE, ONE / 2, 0, 1, 0, 0});          // saturates
    add_ray('{-ONE - 1, ONE / 2, 0, 32'sh7fffffff, 0, 0}); // sub-LSB t
    add_ray('{-ONE, ONE / 2, 0, ONE, 0, 0});            // starts on wall
    add_ray('{-2 * ONE, 0, 0, ONE, 0, 0});              // on bottom plane
    add_ray('{0, 0, 0, 0, 0, 0});
    add_ray('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
              32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
    add_ray('{32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 32'sh80000000, 32'sh80000000});
    add_ray('{32'sh80000000, 0, 32'sh7fffffff, 32'sh7fffffff, -1, 32'sh80000000});
    add_ray('{-1, -1, -1, -1, -1, -1});
    add_ray('{-3 * ONE, ONE / 2, -3 * ONE, ONE, -ONE / 8, ONE});
    run_random(190);

    write_reg(CFG_RADIUS, 32'h0003_8000);
    write_reg(CFG_BOTTOM_Y, -32'sd131072);
    write_reg(CFG_LENGTH, 32'h0005_0000);
    run_random(190);

    write_reg(CFG_RADIUS, 32'hffff_ffff);   // top bit is beyond the register
    write_reg(CFG_BOTTOM_Y, 32'h8000_0000);
    write_reg(CFG_LENGTH, 32'h7fff_ffff);
    run_random(190);

    send_idle = 69;
    recv_idle = 7;
    write_reg(CFG_RADIUS, 0);
    write_reg(CFG_BOTTOM_Y, 32'h7fff_ffff);
    write_reg(CFG_LENGTH, 0);
    run_random(190);

    write_reg(CFG_RADIUS, 32'h0000_4000);
    write_reg(CFG_BOTTOM_Y, 32'h0007_0000);
    write_reg(CFG_LENGTH, 32'h0000_8000);
    write_reg(CFG_UNUSED, 32'h1234_5678);
    run_random(190);

    write_reg(CFG_RADIUS, $urandom_range(32'h0010_0000));
    write_reg(CFG_BOTTOM_Y, $urandom);
    write_reg(CFG_LENGTH, $urandom_range(32'h0100_0000));
    run_random(190);

    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_RADIUS, 32'h0010_0000);
    write_reg(CFG_BOTTOM_Y, -32'sd65536);
    write_reg(CFG_LENGTH, 32'h0100_0000);
    run_random(190);

    write_reg(CFG_RADIUS, $urandom);
    write_reg(CFG_BOTTOM_Y, -$signed(32'($urandom_range(32'h0080_0000))));
    write_reg(CFG_LENGTH, $urandom);
    run_random(190);

    $display("%0d rays sent, %0d results checked across %0d register settings",
             rays_sent, hits_checked, settings_used);
    $display("%0d mismatches", errors);
    if (errors == 0 && expected_hits.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
